### design/log_record_replay_validator_defines.svh
// ----------------------------------------------------------------------------
// Log record replay validator assertion macros
// Shared property wrappers with a common clock and asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_REPLAY_VALIDATOR_DEFINES_SVH
`define LOG_RECORD_REPLAY_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRRV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRRV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/lrrv_pkg.sv
// ----------------------------------------------------------------------------
// Log record replay validator package
// Parse phases, result kinds, the result bundle and the CRC32C byte update.
// ----------------------------------------------------------------------------
package lrrv_pkg;

	localparam int OFFSET_WIDTH_DEF = 48;
	localparam int HEADER_BYTES     = 20;
	localparam int CRC_BYTES        = 4;
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CRC     = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_VALID   = 2'd0,
		KIND_TORN    = 2'd1,
		KIND_CORRUPT = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t        kind;
		logic [63:0]  index;
		logic [63:0]  term;
		logic [31:0]  length;
		logic [47:0]  offset;
		logic [32:0]  torn;
		logic         last;
	} result_t;

	// Reflected CRC32C, one byte folded in bit by bit.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### design/lrrv_parser.sv
// ----------------------------------------------------------------------------
// Log record parser
// Holds the record parse state, folds one byte per step and produces up to
// two results for that byte.
// ----------------------------------------------------------------------------
module lrrv_parser
	import lrrv_pkg::*;
#(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output result_t     res0,
	output result_t     res1,
	output logic [1:0]  res_n
);

	localparam int SW = (OFFSET_WIDTH > 33) ? OFFSET_WIDTH : 33;
	localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};
	localparam logic [32:0] HDR33 = 33'(HEADER_BYTES);
	localparam logic [32:0] CRC33 = 33'(CRC_BYTES);

	phase_t                  phase_q,  phase_upd,  phase_n;
	logic [31:0]             cnt_q,    cnt_upd,    cnt_n;
	logic [63:0]             idx_q,    idx_upd,    idx_n;
	logic [63:0]             term_q,   term_upd,   term_n;
	logic [31:0]             len_q,    len_upd,    len_n;
	logic [31:0]             crc_q,    crc_upd,    crc_n;
	logic [31:0]             scrc_q,   scrc_upd,   scrc_n;
	logic [63:0]             exp_q,    exp_n;
	logic [OFFSET_WIDTH-1:0] start_q,  start_n,    start_sat;
	logic                    halt_q,   halt_n;

	logic        rec_done;
	logic        rec_ok;
	logic [32:0] cnt_inc;
	logic [32:0] extent;
	logic [32:0] consumed;
	logic [SW-1:0] room;

	// Byte update of the parse registers, before any end-of-file handling.
	always_comb begin
		phase_upd = phase_q;
		cnt_upd   = cnt_q;
		idx_upd   = idx_q;
		term_upd  = term_q;
		len_upd   = len_q;
		crc_upd   = crc_q;
		scrc_upd  = scrc_q;
		rec_done  = 1'b0;
		cnt_inc   = {1'b0, cnt_q} + 33'd1;
		case (phase_q)
			PH_HEADER: begin
				crc_upd = crc_byte(crc_q, data_byte);
				if (cnt_q < 32'd8) begin
					idx_upd[{cnt_q[2:0], 3'b000} +: 8] = data_byte;
				end else if (cnt_q < 32'd16) begin
					term_upd[{cnt_q[2:0], 3'b000} +: 8] = data_byte;
				end else begin
					len_upd[{cnt_q[1:0], 3'b000} +: 8] = data_byte;
				end
				if (cnt_inc >= HDR33) begin
					cnt_upd   = '0;
					phase_upd = (len_upd != 32'd0) ? PH_PAYLOAD : PH_CRC;
				end else begin
					cnt_upd = cnt_inc[31:0];
				end
			end
			PH_PAYLOAD: begin
				crc_upd = crc_byte(crc_q, data_byte);
				if (cnt_inc >= {1'b0, len_q}) begin
					cnt_upd   = '0;
					phase_upd = PH_CRC;
				end else begin
					cnt_upd = cnt_inc[31:0];
				end
			end
			PH_CRC: begin
				scrc_upd[{cnt_q[1:0], 3'b000} +: 8] = data_byte;
				cnt_upd  = cnt_inc[31:0];
				rec_done = (cnt_q[1:0] == 2'd3);
			end
			default: begin
				phase_upd = PH_HEADER;
			end
		endcase
		rec_ok = ((crc_q ^ 32'hFFFF_FFFF) == scrc_upd) && (idx_q == exp_q);
	end

	// Record extent, bytes taken so far and the saturated next start offset.
	always_comb begin
		extent = HDR33 + {1'b0, len_q} + CRC33;
		case (phase_upd)
			PH_HEADER:  consumed = 33'(cnt_upd[4:0]);
			PH_PAYLOAD: consumed = HDR33 + {1'b0, cnt_upd};
			default:    consumed = HDR33 + {1'b0, len_upd} + 33'(cnt_upd[1:0]);
		endcase
		room = SW'(OFF_MAX) - SW'(start_q);
		if (SW'(extent) > room) begin
			start_sat = OFF_MAX;
		end else begin
			start_sat = OFFSET_WIDTH'(SW'(start_q) + SW'(extent));
		end
	end

	// Next state.
	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		idx_n   = idx_q;
		term_n  = term_q;
		len_n   = len_q;
		crc_n   = crc_q;
		scrc_n  = scrc_q;
		exp_n   = exp_q;
		start_n = start_q;
		halt_n  = halt_q;
		if (step) begin
			phase_n = phase_upd;
			cnt_n   = cnt_upd;
			idx_n   = idx_upd;
			term_n  = term_upd;
			len_n   = len_upd;
			crc_n   = crc_upd;
			scrc_n  = scrc_upd;
			if (halt_q) begin
				phase_n = phase_q;
				cnt_n   = cnt_q;
				idx_n   = idx_q;
				term_n  = term_q;
				len_n   = len_q;
				crc_n   = crc_q;
				scrc_n  = scrc_q;
			end else if (rec_done && rec_ok) begin
				exp_n   = exp_q + 64'd1;
				start_n = start_sat;
				phase_n = PH_HEADER;
				cnt_n   = '0;
				idx_n   = '0;
				term_n  = '0;
				len_n   = '0;
				crc_n   = 32'hFFFF_FFFF;
				scrc_n  = '0;
			end else if (rec_done && !end_of_file) begin
				halt_n = 1'b1;
			end
			// An end of file on a step puts the whole block back to its reset state.
			if (end_of_file) begin
				phase_n = PH_HEADER;
				cnt_n   = '0;
				idx_n   = '0;
				term_n  = '0;
				len_n   = '0;
				crc_n   = 32'hFFFF_FFFF;
				scrc_n  = '0;
				exp_n   = 64'd1;
				start_n = '0;
				halt_n  = 1'b0;
			end
		end
	end

	// Results for the current byte.
	always_comb begin
		res0  = '0;
		res1  = '0;
		res_n = 2'd0;
		if (step && !halt_q) begin
			res0.index  = idx_upd;
			res0.term   = term_upd;
			res0.length = len_upd;
			res0.offset = 48'(64'(start_q));
			res0.last   = 1'b1;
			if (rec_done) begin
				res_n = 2'd1;
				if (rec_ok) begin
					res0.kind = KIND_VALID;
					if (end_of_file) begin
						res0.last   = 1'b0;
						res1.kind   = KIND_END;
						res1.offset = 48'(64'(start_sat));
						res1.last   = 1'b1;
						res_n       = 2'd2;
					end
				end else if (end_of_file) begin
					res0.kind = KIND_TORN;
					res0.torn = extent;
				end else begin
					res0.kind = KIND_CORRUPT;
				end
			end else if (end_of_file) begin
				res0.kind = KIND_TORN;
				res0.torn = consumed;
				res_n     = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			idx_q   <= '0;
			term_q  <= '0;
			len_q   <= '0;
			crc_q   <= 32'hFFFF_FFFF;
			scrc_q  <= '0;
			exp_q   <= 64'd1;
			start_q <= '0;
			halt_q  <= 1'b0;
		end else begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			idx_q   <= idx_n;
			term_q  <= term_n;
			len_q   <= len_n;
			crc_q   <= crc_n;
			scrc_q  <= scrc_n;
			exp_q   <= exp_n;
			start_q <= start_n;
			halt_q  <= halt_n;
		end
	end

endmodule

### design/log_record_replay_validator.sv
// An input beat is first registered in the input stage; the parser then writes
// its results into the result queue from the input register once the queue
// has room. Throughput: one byte per cycle while the input does not stall;
// set by the single-pass parser stage. The input stalls only while the
// four-entry result queue holds more than two results.
// Reset (arst_n low) clears the parse state, input stage and result queue.
// ----------------------------------------------------------------------------
// Log record replay validator
// Checks CRC32C-framed log records byte by byte and reports each record.
// ----------------------------------------------------------------------------
module log_record_replay_validator
	import lrrv_pkg::*;
#(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [63:0] record_index,
	output logic [63:0] record_term,
	output logic [31:0] command_length,
	output logic [47:0] record_offset,
	output logic [32:0] torn_bytes,
	output logic        is_last
);

`include "log_record_replay_validator_defines.svh"

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;
	logic        advance;
	logic        room;
	logic        pop;

	result_t     res0;
	result_t     res1;
	logic [1:0]  res_n;

	result_t     fifo_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;
	result_t     head;

	// Keep room for a two-result byte so the parser stage never waits mid-item.
	assign room     = (count_q <= 3'd2);
	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	lrrv_parser #(
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte   (byte_s1),
		.end_of_file (eof_s1),
		.res0        (res0),
		.res1        (res1),
		.res_n       (res_n)
	);

	always_ff @(posedge clk) begin
		if (res_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (res_n == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + res_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, res_n} - {2'b00, pop};
		end
	end

	assign out_valid      = (count_q != 3'd0);
	assign head           = fifo_q[rd_ptr_q];
	assign kind           = head.kind;
	assign record_index   = head.index;
	assign record_term    = head.term;
	assign command_length = head.length;
	assign record_offset  = head.offset;
	assign torn_bytes     = head.torn;
	assign is_last        = head.last;

	`LRRV_ASSERT_SAME(a_bound, clk, arst_n, 1'b1, count_q <= 3'd4, "result queue overflow")
	`LRRV_ASSERT_SAME(a_pair, clk, arst_n, res_n == 2'd2, res1.kind == KIND_END, "bad pair")
	`LRRV_ASSERT_SAME(a_stall, clk, arst_n, in_stall, valid_s1 && count_q >= 3'd3, "bad stall")
	`LRRV_ASSERT_NEXT(a_pop, clk, arst_n, pop && !advance, count_q == $past(count_q) - 3'd1, "bad pop")

endmodule
